FILE: design/mstt_pkg.sv
// ----------------------------------------------------------------------------
// mstt_pkg
// Shared codes, widths and controller/datapath types of the timer table.
// ----------------------------------------------------------------------------
package mstt_pkg;

    localparam int NUM_SLOTS_DEF = 8;

    localparam int OP_W   = 2;
    localparam int TIME_W = 32;
    localparam int ID_W   = 4;
    localparam int KIND_W = 3;

    localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE  = 2'd1;
    localparam logic [OP_W-1:0] OP_SERVICE = 2'd2;
    localparam logic [OP_W-1:0] OP_ANSWER  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIRE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ANSWER = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DONE   = 3'd4;

    typedef struct packed {
        logic latch;
        logic exec;
        logic fire;
        logic advance;
        logic done;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic hit;
        logic idx_last;
    } dp_status_t;

endpackage

FILE: design/mstt_if.sv
// ----------------------------------------------------------------------------
// mstt_req_if / mstt_rsp_if
// Valid/ready channels carrying request and result transactions.
// ----------------------------------------------------------------------------
interface mstt_req_if;
    logic                         valid;
    logic                         ready;
    logic [mstt_pkg::OP_W-1:0]    op;
    logic [mstt_pkg::TIME_W-1:0]  now_ms;
    logic [mstt_pkg::TIME_W-1:0]  period_ms;
    logic [mstt_pkg::ID_W-1:0]    slot_id;

    modport source (output valid, op, now_ms, period_ms, slot_id, input ready);
    modport sink   (input valid, op, now_ms, period_ms, slot_id, output ready);
endinterface

interface mstt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [mstt_pkg::KIND_W-1:0]  kind;
    logic [mstt_pkg::ID_W-1:0]    slot_id_res;
    logic [mstt_pkg::TIME_W-1:0]  fired_period;
    logic                         ok;
    logic                         last;

    modport source (output valid, kind, slot_id_res, fired_period, ok, last, input ready);
    modport sink   (input valid, kind, slot_id_res, fired_period, ok, last, output ready);
endinterface

FILE: design/multi_slot_rearm_timer_table.sv
// ----------------------------------------------------------------------------
// multi_slot_rearm_timer_table
// Timer slot table with add, remove, service scan and callback answer.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel (op, now_ms, period_ms, slot_id) and
// results leave on the rsp channel (kind, slot_id_res, fired_period, ok,
// last); each is a valid/ready transaction.
// One request is in work at a time. Add, remove and answer load their result
// into the output register once it is free, and ready returns in the cycle in
// which that result appears. Service scans the slots one at a time through
// the interval and due-time memories, each with a read state and a compare
// state; it loads one fire result per due slot as the register frees and a
// closing done result with last set, and ready returns with the done result.
// Results pass through a single output register, so a new request can be
// accepted while the previous result still waits. When the receiver stalls,
// the sequencer holds at its next result until the register frees.
// Reset clears all active and pending flags, the service time and the result
// valid flag; interval and due memories are not cleared and are only used for
// slots that add has written.
// ----------------------------------------------------------------------------
module multi_slot_rearm_timer_table #(
    parameter int NUM_SLOTS = mstt_pkg::NUM_SLOTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mstt_req_if.sink   req,
    mstt_rsp_if.source rsp
);
    import mstt_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    mstt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.op),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    mstt_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_op           (req.op),
        .req_now_ms       (req.now_ms),
        .req_period_ms    (req.period_ms),
        .req_slot_id      (req.slot_id),
        .cmd              (cmd),
        .status           (status),
        .rsp_valid        (rsp.valid),
        .rsp_ready        (rsp.ready),
        .rsp_kind         (rsp.kind),
        .rsp_slot_id_res  (rsp.slot_id_res),
        .rsp_fired_period (rsp.fired_period),
        .rsp_ok           (rsp.ok),
        .rsp_last         (rsp.last)
    );

endmodule

FILE: design/mstt_ctrl.sv
// ----------------------------------------------------------------------------
// mstt_ctrl
// Sequencer: accepts one request, runs it, scans slots for service.
// ----------------------------------------------------------------------------
module mstt_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    input  logic [mstt_pkg::OP_W-1:0]    req_op,
    output logic                         req_ready,
    input  mstt_pkg::dp_status_t         status,
    output mstt_pkg::ctrl_cmd_t          cmd
);
    import mstt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        req_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = (req_op == OP_SERVICE) ? S_LOAD : S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (status.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LOAD:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!status.hit)
                begin
                    cmd.advance = 1'b1;
                    state_next  = status.idx_last ? S_DONE : S_LOAD;
                end
                else if (status.out_free)
                begin
                    cmd.fire   = 1'b1;
                    state_next = status.idx_last ? S_DONE : S_LOAD;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.done   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/mstt_dp.sv
// ----------------------------------------------------------------------------
// mstt_dp
// Slot state, interval and due-time memories, scan index, result register.
// ----------------------------------------------------------------------------
module mstt_dp #(
    parameter int NUM_SLOTS = mstt_pkg::NUM_SLOTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [mstt_pkg::OP_W-1:0]    req_op,
    input  logic [mstt_pkg::TIME_W-1:0]  req_now_ms,
    input  logic [mstt_pkg::TIME_W-1:0]  req_period_ms,
    input  logic [mstt_pkg::ID_W-1:0]    req_slot_id,
    input  mstt_pkg::ctrl_cmd_t          cmd,
    output mstt_pkg::dp_status_t         status,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output logic [mstt_pkg::KIND_W-1:0]  rsp_kind,
    output logic [mstt_pkg::ID_W-1:0]    rsp_slot_id_res,
    output logic [mstt_pkg::TIME_W-1:0]  rsp_fired_period,
    output logic                         rsp_ok,
    output logic                         rsp_last
);
    import mstt_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int EW    = (IDX_W > ID_W) ? IDX_W : ID_W;

    logic [OP_W-1:0]      op_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [TIME_W-1:0]    per_reg;
    logic [ID_W-1:0]      id_reg;
    logic [TIME_W-1:0]    service_time_reg;
    logic [NUM_SLOTS-1:0] active_reg;
    logic [NUM_SLOTS-1:0] active_next;
    logic [NUM_SLOTS-1:0] pending_reg;
    logic [NUM_SLOTS-1:0] pending_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic [TIME_W-1:0]    rd_period_reg;
    logic [TIME_W-1:0]    rd_due_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [KIND_W-1:0]    out_kind_reg;
    logic [KIND_W-1:0]    out_kind_next;
    logic [ID_W-1:0]      out_id_reg;
    logic [ID_W-1:0]      out_id_next;
    logic [TIME_W-1:0]    out_period_reg;
    logic [TIME_W-1:0]    out_period_next;
    logic                 out_ok_reg;
    logic                 out_ok_next;
    logic                 out_last_reg;
    logic                 out_last_next;

    logic [TIME_W-1:0]    period_mem [NUM_SLOTS];
    logic [TIME_W-1:0]    due_mem [NUM_SLOTS];
    logic                 we;
    logic [IDX_W-1:0]     wr_addr;
    logic [TIME_W-1:0]    wr_due;

    logic [NUM_SLOTS-1:0] free_vec;
    logic [NUM_SLOTS-1:0] low_free;
    logic [IDX_W-1:0]     add_idx;
    logic                 table_full;
    logic [EW-1:0]        id_ext;
    logic [IDX_W-1:0]     sel;
    logic                 id_ok;
    logic                 add_ok;
    logic                 rm_ok;
    logic                 ans_ok;
    logic [TIME_W-1:0]    diff;
    logic                 emit;

    assign free_vec   = ~active_reg;
    assign low_free   = free_vec & (~free_vec + NUM_SLOTS'(1));
    assign table_full = (active_reg == '1);

    always_comb
    begin
        add_idx = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (low_free[i])
            begin
                add_idx = add_idx | IDX_W'(i);
            end
        end
    end

    assign id_ext = EW'(id_reg);
    assign sel    = IDX_W'(id_ext - EW'(1));
    assign id_ok  = (id_reg != '0) && (32'(id_reg) <= 32'(NUM_SLOTS));
    assign add_ok = (per_reg != '0) && !table_full;
    assign rm_ok  = id_ok && active_reg[sel];
    assign ans_ok = id_ok && active_reg[sel] && pending_reg[sel];

    assign diff            = service_time_reg - rd_due_reg;
    assign status.hit      = active_reg[idx_reg] && !pending_reg[idx_reg] && !diff[TIME_W-1];
    assign status.idx_last = (idx_reg == IDX_W'(NUM_SLOTS - 1));
    assign status.out_free = !out_valid_reg || rsp_ready;

    assign emit = cmd.exec || cmd.fire || cmd.done;

    always_comb
    begin
        active_next     = active_reg;
        pending_next    = pending_reg;
        we              = 1'b0;
        wr_addr         = add_idx;
        wr_due          = now_reg + per_reg;
        out_kind_next   = out_kind_reg;
        out_id_next     = out_id_reg;
        out_period_next = out_period_reg;
        out_ok_next     = out_ok_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end

        if (cmd.exec)
        begin
            out_period_next = '0;
            out_last_next   = 1'b1;
            out_ok_next     = 1'b0;
            out_id_next     = '0;
            unique case (op_reg)
                OP_ADD:
                begin
                    out_kind_next = KIND_ADD;
                    if (add_ok)
                    begin
                        active_next[add_idx]  = 1'b1;
                        pending_next[add_idx] = 1'b0;
                        we                    = 1'b1;
                        out_ok_next           = 1'b1;
                        out_id_next           = ID_W'({1'b0, add_idx} + 1'b1);
                    end
                end
                OP_REMOVE:
                begin
                    out_kind_next = KIND_REMOVE;
                    if (rm_ok)
                    begin
                        active_next[sel]  = 1'b0;
                        pending_next[sel] = 1'b0;
                        out_ok_next       = 1'b1;
                        out_id_next       = id_reg;
                    end
                end
                OP_ANSWER:
                begin
                    out_kind_next = KIND_ANSWER;
                    if (ans_ok)
                    begin
                        pending_next[sel] = 1'b0;
                        if (per_reg == '0)
                        begin
                            active_next[sel] = 1'b0;
                        end
                        else
                        begin
                            we      = 1'b1;
                            wr_addr = sel;
                            wr_due  = service_time_reg + per_reg;
                        end
                        out_ok_next = 1'b1;
                        out_id_next = id_reg;
                    end
                end
                OP_SERVICE:
                begin
                    out_kind_next = KIND_DONE;
                end
            endcase
        end

        if (cmd.fire)
        begin
            pending_next[idx_reg] = 1'b1;
            out_kind_next         = KIND_FIRE;
            out_id_next           = ID_W'({1'b0, idx_reg} + 1'b1);
            out_period_next       = rd_period_reg;
            out_ok_next           = 1'b0;
            out_last_next         = 1'b0;
        end

        if (cmd.done)
        begin
            out_kind_next   = KIND_DONE;
            out_id_next     = '0;
            out_period_next = '0;
            out_ok_next     = 1'b0;
            out_last_next   = 1'b1;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.latch && (req_op == OP_SERVICE))
        begin
            idx_next = '0;
        end
        else if (cmd.advance || cmd.fire)
        begin
            idx_next = status.idx_last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= '0;
            pending_reg      <= '0;
            service_time_reg <= '0;
            idx_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            pending_reg   <= pending_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cmd.latch && (req_op == OP_SERVICE))
            begin
                service_time_reg <= req_now_ms;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg  <= req_op;
            now_reg <= req_now_ms;
            per_reg <= req_period_ms;
            id_reg  <= req_slot_id;
        end
        out_kind_reg   <= out_kind_next;
        out_id_reg     <= out_id_next;
        out_period_reg <= out_period_next;
        out_ok_reg     <= out_ok_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            period_mem[wr_addr] <= per_reg;
            due_mem[wr_addr]    <= wr_due;
        end
        rd_period_reg <= period_mem[idx_reg];
        rd_due_reg    <= due_mem[idx_reg];
    end

    assign rsp_valid        = out_valid_reg;
    assign rsp_kind         = out_kind_reg;
    assign rsp_slot_id_res  = out_id_reg;
    assign rsp_fired_period = out_period_reg;
    assign rsp_ok           = out_ok_reg;
    assign rsp_last         = out_last_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> status.out_free)
        else $error("result loaded while result register is occupied");

    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.latch, cmd.exec, cmd.fire, cmd.advance, cmd.done}))
        else $error("conflicting controller commands");

    a_fire_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fire |-> status.hit)
        else $error("fire issued for a slot that is not due");

    a_fire_pend: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fire |=> pending_reg[$past(idx_reg)])
        else $error("fired slot not marked pending");

    a_pend_active: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg & ~active_reg) == '0)
        else $error("pending slot is not active");

endmodule

FILE: bench/mstt_checker.sv
// ----------------------------------------------------------------------------
// mstt_checker
// Watches the request and result channels of the timer table. It predicts the
// results of every accepted request from its own copy of the slot state and
// compares each accepted result, field by field, with the oldest one owed.
// ----------------------------------------------------------------------------
module mstt_checker #(
    parameter int NUM_SLOTS = mstt_pkg::NUM_SLOTS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    mstt_req_if  req,
    mstt_rsp_if  rsp,
    output int   fail_count,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import mstt_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   slot_id_res;
        logic [TIME_W-1:0] fired_period;
        logic              ok;
        logic              last;
    } timer_result_t;

    logic              slot_active  [NUM_SLOTS];
    logic              slot_pending [NUM_SLOTS];
    logic [TIME_W-1:0] slot_period  [NUM_SLOTS];
    logic [TIME_W-1:0] slot_due     [NUM_SLOTS];
    logic [TIME_W-1:0] service_time;

    timer_result_t results_owed[$];
    timer_result_t want;
    timer_result_t got;

    function automatic timer_result_t make_result(
        input logic [KIND_W-1:0] kind,
        input logic [ID_W-1:0]   id,
        input logic [TIME_W-1:0] per,
        input logic              ok,
        input logic              last
    );
        timer_result_t r;
        r.kind         = kind;
        r.slot_id_res  = id;
        r.fired_period = per;
        r.ok           = ok;
        r.last         = last;
        return r;
    endfunction

    task automatic run_timer_op(
        input logic [OP_W-1:0]   op,
        input logic [TIME_W-1:0] now,
        input logic [TIME_W-1:0] per,
        input logic [ID_W-1:0]   id
    );
        int                slot;
        logic              placed;
        logic              in_range;
        logic [TIME_W-1:0] lag;
        slot     = int'(id) - 1;
        placed   = 1'b0;
        in_range = (id >= 1) && (int'(id) <= NUM_SLOTS);
        case (op)
            OP_ADD:
            begin
                if (per != '0)
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (!placed && !slot_active[i])
                        begin
                            placed          = 1'b1;
                            slot_active[i]  = 1'b1;
                            slot_pending[i] = 1'b0;
                            slot_period[i]  = per;
                            slot_due[i]     = now + per;
                            results_owed.push_back(
                                make_result(KIND_ADD, ID_W'(i + 1), '0, 1'b1, 1'b1));
                        end
                    end
                end
                if (!placed)
                    results_owed.push_back(make_result(KIND_ADD, '0, '0, 1'b0, 1'b1));
            end
            OP_REMOVE:
            begin
                if (in_range && slot_active[slot])
                begin
                    slot_active[slot]  = 1'b0;
                    slot_pending[slot] = 1'b0;
                    results_owed.push_back(make_result(KIND_REMOVE, id, '0, 1'b1, 1'b1));
                end
                else
                    results_owed.push_back(make_result(KIND_REMOVE, '0, '0, 1'b0, 1'b1));
            end
            OP_SERVICE:
            begin
                service_time = now;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (slot_active[i] && !slot_pending[i])
                    begin
                        lag = now - slot_due[i];
                        if (!lag[TIME_W-1])
                        begin
                            slot_pending[i] = 1'b1;
                            results_owed.push_back(make_result(KIND_FIRE, ID_W'(i + 1),
                                                               slot_period[i], 1'b0, 1'b0));
                        end
                    end
                end
                results_owed.push_back(make_result(KIND_DONE, '0, '0, 1'b0, 1'b1));
            end
            default:
            begin
                if (in_range && slot_active[slot] && slot_pending[slot])
                begin
                    slot_pending[slot] = 1'b0;
                    if (per == '0)
                        slot_active[slot] = 1'b0;
                    else
                    begin
                        slot_period[slot] = per;
                        slot_due[slot]    = service_time + per;
                    end
                    results_owed.push_back(make_result(KIND_ANSWER, id, '0, 1'b1, 1'b1));
                end
                else
                    results_owed.push_back(make_result(KIND_ANSWER, '0, '0, 1'b0, 1'b1));
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_active[i]  = 1'b0;
                slot_pending[i] = 1'b0;
                slot_period[i]  = '0;
                slot_due[i]     = '0;
            end
            service_time = '0;
            results_owed.delete();
            fail_count = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                run_timer_op(req.op, req.now_ms, req.period_ms, req.slot_id);
            if (rsp.valid && rsp.ready)
            begin
                got = make_result(rsp.kind, rsp.slot_id_res, rsp.fired_period, rsp.ok, rsp.last);
                if (results_owed.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result: kind %0d id %0d period %h ok %0b last %0b",
                                 $realtime, got.kind, got.slot_id_res, got.fired_period,
                                 got.ok, got.last);
                    fail_count++;
                end
                else
                begin
                    want = results_owed.pop_front();
                    if (got.kind !== want.kind || got.slot_id_res !== want.slot_id_res ||
                        got.fired_period !== want.fired_period || got.ok !== want.ok ||
                        got.last !== want.last)
                    begin
                        if (fail_count < 10)
                            $display({"%0t: result mismatch: expected kind %0d id %0d ",
                                      "period %h ok %0b last %0b, got kind %0d id %0d ",
                                      "period %h ok %0b last %0b"},
                                     $realtime, want.kind, want.slot_id_res,
                                     want.fired_period, want.ok, want.last,
                                     got.kind, got.slot_id_res, got.fired_period,
                                     got.ok, got.last);
                        fail_count++;
                    end
                end
            end
        end
        outstanding = results_owed.size();
    end

endmodule

FILE: bench/tb_multi_slot_rearm_timer_table.sv
// ----------------------------------------------------------------------------
// tb_multi_slot_rearm_timer_table
// Drives the timer table with a directed sequence covering each operation and
// failure case, then random add/remove/service/answer traffic on a moving
// millisecond clock, under three sender/receiver stall patterns and one long
// receiver hold-off. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_multi_slot_rearm_timer_table;
    timeunit 1ns;
    timeprecision 1ps;

    import mstt_pkg::*;

    localparam int SLOT_COUNT     = NUM_SLOTS_DEF;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 2 * SLOT_COUNT + 8;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int                fail_count;
    int                outstanding;
    int                tx_idle_pct = 29;
    int                rx_idle_pct = 61;
    int                hold_asked  = 0;
    int                hold_served = 0;
    int                idle_cycles = 0;
    logic [TIME_W-1:0] cur_ms;

    always #6 clk = ~clk;

    mstt_req_if req();
    mstt_rsp_if rsp();

    multi_slot_rearm_timer_table #(
        .NUM_SLOTS(SLOT_COUNT)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    mstt_checker #(
        .NUM_SLOTS(SLOT_COUNT)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rsp.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_asked != hold_served)
            begin
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_served++;
            end
            else
                rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_op(
        input logic [OP_W-1:0]   op,
        input logic [TIME_W-1:0] now,
        input logic [TIME_W-1:0] per,
        input logic [ID_W-1:0]   id
    );
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid     <= 1'b1;
        req.op        <= op;
        req.now_ms    <= now;
        req.period_ms <= per;
        req.slot_id   <= id;
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        req.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic random_ops(input int count);
        int                roll;
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] per;
        logic [ID_W-1:0]   id;
        for (int n = 0; n < count; n++)
        begin
            roll   = $urandom_range(99);
            now    = $urandom();
            per    = $urandom();
            id     = ID_W'($urandom_range(15));
            cur_ms = cur_ms + $urandom_range(40);
            if ($urandom_range(9) != 0)
                now = cur_ms;
            if (roll < 25)
            begin
                op = OP_ADD;
                case ($urandom_range(9))
                    0:       per = '0;
                    1:       per = $urandom();
                    default: per = $urandom_range(1, 120);
                endcase
            end
            else if (roll < 35)
            begin
                op = OP_REMOVE;
                if ($urandom_range(4) != 0)
                    id = ID_W'($urandom_range(1, SLOT_COUNT));
            end
            else if (roll < 65)
                op = OP_SERVICE;
            else
            begin
                op = OP_ANSWER;
                if ($urandom_range(7) != 0)
                    id = ID_W'($urandom_range(1, SLOT_COUNT));
                roll = $urandom_range(99);
                if (roll < 15)
                    per = '0;
                else if (roll >= 25)
                    per = $urandom_range(1, 120);
            end
            send_op(op, now, per, id);
        end
    endtask

    initial
    begin
        logic [TIME_W-1:0] add_periods[8];
        logic [TIME_W-1:0] t0;
        add_periods = '{32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'd10, 32'd20, 32'd5, 32'd100};
        t0            = 32'hFFFF_FFF0;
        req.valid     = 1'b0;
        req.op        = OP_ADD;
        req.now_ms    = '0;
        req.period_ms = '0;
        req.slot_id   = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_op(OP_ADD,     t0,           '0,           4'd1);
        send_op(OP_REMOVE,  t0,           32'd5,        4'd0);
        send_op(OP_REMOVE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
        send_op(OP_ANSWER,  '0,           32'd7,        4'd9);
        send_op(OP_REMOVE,  '0,           '0,           4'd3);
        send_op(OP_ANSWER,  '0,           32'd4,        4'd1);
        for (int i = 0; i < SLOT_COUNT; i++)
            send_op(OP_ADD, t0, add_periods[i % 8], '0);
        send_op(OP_ADD,     t0,           32'd3,        '0);
        send_op(OP_SERVICE, t0 + 10,      '0,           '0);
        send_op(OP_SERVICE, t0 + 10,      '0,           '0);
        send_op(OP_ANSWER,  '0,           '0,           4'd1);
        send_op(OP_ANSWER,  '0,           32'hFFFF_FFFF, 4'd2);
        send_op(OP_REMOVE,  '0,           '0,           4'd5);
        send_op(OP_ANSWER,  '0,           32'd9,        4'd5);
        send_op(OP_ANSWER,  '0,           32'd3,        4'd7);
        send_op(OP_SERVICE, 32'hFFFF_FFFF, '0,          '0);
        send_op(OP_ADD,     32'hFFFF_FFFF, 32'd1,       '0);
        send_op(OP_SERVICE, '0,           '0,           '0);
        cur_ms = '0;

        random_ops(15);
        hold_asked++;
        repeat (8)
            send_op(OP_SERVICE, cur_ms, $urandom(), ID_W'($urandom_range(15)));
        random_ops(15);
        wait_for_results();

        tx_idle_pct = 61;
        rx_idle_pct = 29;
        cur_ms      = $urandom();
        random_ops(20);
        wait_for_results();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_ops(20);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
design/mstt_pkg.sv
design/mstt_if.sv
design/mstt_ctrl.sv
design/mstt_dp.sv
design/multi_slot_rearm_timer_table.sv
bench/mstt_checker.sv
bench/tb_multi_slot_rearm_timer_table.sv
